>>> hw/rtl/ptud_pkg.sv
// ----------------------------------------------------------------------------
// ptud_pkg: shared definitions for the polled timer microsecond delay block
// Widths, register codes, sequencer states and divider control types.
// ----------------------------------------------------------------------------
`default_nettype none

package ptud_pkg;

    localparam int COUNT_BITS = 32;                  // timer counter width, 16..64
    localparam int DIV_BITS   = COUNT_BITS + 1;      // divider width: step plus carry room
    localparam int CPU_BITS   = 16;                  // counts per microsecond
    localparam int PER_BITS   = 32;
    localparam int TV_BITS    = 32;
    localparam int USEC_BITS  = 32;
    localparam int CNT_BITS   = $clog2(DIV_BITS + 1);
    localparam int SUM_BITS   = ((DIV_BITS > USEC_BITS) ? DIV_BITS : USEC_BITS) + 1;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [USEC_BITS-1:0] USEC_MAX = '1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_COUNTS_PER_USEC   = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COUNTS_PER_PERIOD = 1'b1;

    localparam logic FUNC_START  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LOAD = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_ACC  = 5'b01000,
        ST_FIN  = 5'b10000
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

`default_nettype wire

>>> hw/rtl/polled_timer_usec_delay_top.sv
// ----------------------------------------------------------------------------
// polled_timer_usec_delay_top: busy-wait delay accumulator
// Turns successive down-counter readings into elapsed microseconds.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_stall    | func, timer_value, target_usecs
//  out     | output    | o_out_valid / i_out_stall  | done_res, elapsed_usecs
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | cfg_index, cfg_data
//
//  start transaction: idle, then the finish state, then the output register
//  sample transaction: load, divide, accumulate and finish states, then the
//    output register; the divider retires one quotient bit per cycle
//  one transaction at a time; the next is taken once the result is in the
//    output register, which holds it until the downstream stall drops
//  synchronous reset clears sequencer, accumulators and config defaults
// ----------------------------------------------------------------------------
`default_nettype none

module polled_timer_usec_delay_top (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire                                 i_func,
    input  wire [ptud_pkg::TV_BITS-1:0]         i_timer_value,
    input  wire [ptud_pkg::USEC_BITS-1:0]       i_target_usecs,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic                                o_done_res,
    output logic [ptud_pkg::USEC_BITS-1:0]      o_elapsed_usecs,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire [ptud_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire [ptud_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import ptud_pkg::*;

    t_state                r_state;
    logic [CPU_BITS-1:0]   r_cpu;
    logic [PER_BITS-1:0]   r_cpp;
    logic [COUNT_BITS-1:0] r_prev;
    logic [CPU_BITS-1:0]   r_leftover;
    logic [USEC_BITS-1:0]  r_usecs;
    logic [USEC_BITS-1:0]  r_goal;
    logic [COUNT_BITS-1:0] r_step;
    logic [DIV_BITS-1:0]   r_whole;
    logic                  r_out_valid;
    logic                  r_done_res;
    logic [USEC_BITS-1:0]  r_elapsed;

    logic                  in_accept;
    logic                  out_load;
    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] per;
    logic [COUNT_BITS-1:0] n_step;
    logic [CPU_BITS-1:0]   divisor;
    logic [CPU_BITS:0]     part;
    logic [CPU_BITS:0]     part_sub;
    logic                  carry;
    logic [SUM_BITS-1:0]   sum;
    logic                  sat;
    t_div_ctl              div_ctl;
    t_div_sts              div_sts;
    logic [DIV_BITS-1:0]   div_quo;
    logic [CPU_BITS-1:0]   div_rem;

    assign in_accept   = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign out_load    = (r_state == ST_FIN) && (!r_out_valid || !i_out_stall);

    always_comb begin
        cur    = COUNT_BITS'(i_timer_value);
        per    = COUNT_BITS'(r_cpp);
        // reading above the previous one means the counter reloaded
        n_step = (r_prev < cur) ? (r_prev + (per - cur)) : (r_prev - cur);
        divisor = (r_cpu == '0) ? CPU_BITS'(1) : r_cpu;
        // remainder of the step plus leftover counts, folded back at most once
        part     = {1'b0, div_rem} + {1'b0, r_leftover};
        part_sub = part - {1'b0, divisor};
        carry    = part >= {1'b0, divisor};
        sum    = SUM_BITS'(r_usecs) + SUM_BITS'(r_whole);
        sat    = sum >= SUM_BITS'(USEC_MAX);
        div_ctl.start = (r_state == ST_LOAD);
    end

    ptud_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (div_ctl),
        .i_dividend  (DIV_BITS'(r_step)),
        .i_divisor   (divisor),
        .o_sts       (div_sts),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_state <= (i_func == FUNC_START) ? ST_FIN : ST_LOAD;
                    end
                end
                ST_LOAD: r_state <= ST_DIV;
                ST_DIV: begin
                    if (div_sts.done) begin
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: r_state <= ST_FIN;
                ST_FIN: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // configuration and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu      <= CPU_BITS'(1);
            r_cpp      <= '1;
            r_prev     <= '0;
            r_leftover <= '0;
            r_usecs    <= '0;
            r_goal     <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_COUNTS_PER_USEC:   r_cpu <= i_cfg_data[CPU_BITS-1:0];
                    CFG_COUNTS_PER_PERIOD: r_cpp <= i_cfg_data[PER_BITS-1:0];
                    default: ;
                endcase
            end
            if (in_accept) begin
                r_prev <= cur;
                if (i_func == FUNC_START) begin
                    r_goal     <= i_target_usecs;
                    r_leftover <= '0;
                    r_usecs    <= '0;
                end
            end
            if ((r_state == ST_DIV) && div_sts.done) begin
                r_leftover <= carry ? part_sub[CPU_BITS-1:0] : part[CPU_BITS-1:0];
            end
            if (r_state == ST_ACC) begin
                r_usecs <= sat ? USEC_MAX : sum[USEC_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_step <= n_step;
        end
        if ((r_state == ST_DIV) && div_sts.done) begin
            r_whole <= div_quo + DIV_BITS'(carry);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_done_res <= (r_usecs >= r_goal);
            r_elapsed  <= r_usecs;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_done_res      = r_done_res;
    assign o_elapsed_usecs = r_elapsed;

`ifndef SYNTH
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sts.done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

    a_div_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (div_sts.busy || div_sts.done))
        else $error("divider idle in the divide state");

    a_leftover_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC) |-> (r_leftover < divisor))
        else $error("leftover counts not below counts per microsecond");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != ST_IDLE))
        else $error("sequencer idle right after a transaction");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_FIN))
        else $error("result raised outside the finish state");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/ptud_div.sv
// ----------------------------------------------------------------------------
// ptud_div: radix-2 restoring divider
// One quotient bit per cycle; the divisor must hold steady while busy.
// ----------------------------------------------------------------------------
`default_nettype none

module ptud_div (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire ptud_pkg::t_div_ctl       i_ctl,
    input  wire [ptud_pkg::DIV_BITS-1:0]  i_dividend,
    input  wire [ptud_pkg::CPU_BITS-1:0]  i_divisor,
    output ptud_pkg::t_div_sts            o_sts,
    output logic [ptud_pkg::DIV_BITS-1:0] o_quotient,
    output logic [ptud_pkg::CPU_BITS-1:0] o_remainder
);
    import ptud_pkg::*;

    logic [DIV_BITS-1:0] r_quo, n_quo;
    logic [CPU_BITS-1:0] r_rem, n_rem;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [CPU_BITS:0]   trial;
    logic [CPU_BITS:0]   diff;
    logic                ge;

    always_comb begin
        trial = {r_rem, r_quo[DIV_BITS-1]};
        ge    = trial >= {1'b0, i_divisor};
        diff  = trial - {1'b0, i_divisor};
        n_rem = ge ? diff[CPU_BITS-1:0] : trial[CPU_BITS-1:0];
        n_quo = {r_quo[DIV_BITS-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(DIV_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_sts.busy  = r_busy;
    assign o_sts.done  = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

>>> tb/polled_timer_usec_delay_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polled_timer_usec_delay_top_tb: self-checking bench for the usec delay block
// Feeds start and timer sample transactions, first from a short table of
// corner cases and then as random countdown sequences with wraps and noise.
// A local accumulator model predicts elapsed microseconds and the done flag
// under several counts-per-usec and period settings. Input and output sides
// idle at random.
// ----------------------------------------------------------------------------

module polled_timer_usec_delay_top_tb;

    import ptud_pkg::*;

    localparam logic [63:0] CNT_MASK = (COUNT_BITS >= 64) ? {64{1'b1}} :
                                       ((64'd1 << COUNT_BITS) - 64'd1);
    localparam int N_DIRECTED  = 17;
    localparam int N_PHASES    = 6;
    localparam int ITEMS_PHASE = 105;

    typedef struct packed {
        logic                 done;
        logic [USEC_BITS-1:0] elapsed;
    } t_delay_result;

    typedef struct packed {
        logic                 func;
        logic [TV_BITS-1:0]   tv;
        logic [USEC_BITS-1:0] tgt;
        logic                 typed;
        t_delay_result        res;
    } t_dir_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic                     i_func = FUNC_START;
    logic [TV_BITS-1:0]       i_timer_value = '0;
    logic [USEC_BITS-1:0]     i_target_usecs = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic                     o_done_res;
    logic [USEC_BITS-1:0]     o_elapsed_usecs;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = CFG_COUNTS_PER_USEC;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    polled_timer_usec_delay_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_timer_value   (i_timer_value),
        .i_target_usecs  (i_target_usecs),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_done_res      (o_done_res),
        .o_elapsed_usecs (o_elapsed_usecs),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // model state and register copies
    logic [CPU_BITS-1:0]   cpu_cfg;
    logic [PER_BITS-1:0]   period_cfg;
    logic [COUNT_BITS-1:0] last_reading;
    logic [DIV_BITS-1:0]   spare_counts;
    logic [USEC_BITS-1:0]  usec_total;
    logic [USEC_BITS-1:0]  goal_usecs;

    t_delay_result pending_elapsed_q[$];
    t_dir_row      directed_rows [0:N_DIRECTED-1];
    int            err_cnt = 0;
    int            burst_left = 0;
    int            stall_run = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("polled_timer_usec_delay_top_tb: FAIL");
        $finish;
    end

    function automatic t_delay_result advance_delay(input logic func,
                                                    input logic [TV_BITS-1:0] tv,
                                                    input logic [USEC_BITS-1:0] tgt);
        logic [63:0]   cur;
        logic [63:0]   step;
        logic [63:0]   divisor;
        logic [63:0]   whole;
        logic [63:0]   part;
        logic [63:0]   room;
        t_delay_result res;
        cur = {32'b0, tv} & CNT_MASK;
        if (func == FUNC_START) begin
            goal_usecs   = tgt;
            last_reading = cur[COUNT_BITS-1:0];
            spare_counts = '0;
            usec_total   = '0;
        end else begin
            // reading went up: the counter reloaded from the period
            if (64'(last_reading) < cur)
                step = (64'(last_reading) + ((64'(period_cfg) & CNT_MASK) - cur)) & CNT_MASK;
            else
                step = (64'(last_reading) - cur) & CNT_MASK;
            last_reading = cur[COUNT_BITS-1:0];
            divisor = (cpu_cfg == '0) ? 64'd1 : 64'(cpu_cfg);
            whole = step / divisor;
            part  = (step % divisor) + 64'(spare_counts);
            if (part >= divisor) begin
                part  = part - divisor;
                whole = whole + 64'd1;
            end
            spare_counts = part[DIV_BITS-1:0];
            room = 64'(USEC_MAX) - 64'(usec_total);
            if (whole >= room)
                usec_total = USEC_MAX;
            else
                usec_total = usec_total + whole[USEC_BITS-1:0];
        end
        res.done    = (usec_total >= goal_usecs);
        res.elapsed = usec_total;
        return res;
    endfunction

    task automatic flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // one transaction on the input channel; valid is left high for the caller
    task automatic drive_txn(input logic func, input logic [TV_BITS-1:0] tv,
                             input logic [USEC_BITS-1:0] tgt, input logic typed,
                             input t_delay_result typed_res);
        t_delay_result res;
        i_in_valid     <= 1'b1;
        i_func         <= func;
        i_timer_value  <= tv;
        i_target_usecs <= tgt;
        do
            @(posedge i_clk);
        while (o_in_stall);
        res = advance_delay(func, tv, tgt);
        pending_elapsed_q.push_back(typed ? typed_res : res);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 45);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                    : $urandom_range(0, 15);
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        if (idx == CFG_COUNTS_PER_USEC)
            cpu_cfg = data[CPU_BITS-1:0];
        else
            period_cfg = data[PER_BITS-1:0];
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reconfigure(input logic [CPU_BITS-1:0] cpu,
                               input logic [PER_BITS-1:0] per);
        logic [15:0] junk;
        junk = 16'($urandom);
        i_in_valid <= 1'b0;
        while (pending_elapsed_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        // upper data bits are outside the register and must be dropped
        cfg_write(CFG_COUNTS_PER_USEC, {junk, cpu});
        cfg_write(CFG_COUNTS_PER_PERIOD, 32'(per));
    endtask

    // countdown sequences: a start, then readings falling by random amounts
    task automatic run_random(input int n_items);
        logic [63:0]          counter;
        logic [63:0]          delta;
        logic [63:0]          span;
        logic [USEC_BITS-1:0] tgt;
        int                   seq_left;
        int                   r;
        int                   k;
        seq_left = 0;
        counter  = '0;
        for (k = 0; k < n_items; k++) begin
            r = $urandom_range(0, 99);
            if (seq_left == 0 || r < 4) begin
                case ($urandom_range(0, 5))
                    0:       tgt = '0;
                    1:       tgt = $urandom;
                    2:       tgt = $urandom_range(1, 20);
                    default: tgt = $urandom_range(20, 120);
                endcase
                counter  = 64'($urandom);
                seq_left = $urandom_range(3, 60);
                drive_txn(FUNC_START, counter[TV_BITS-1:0], tgt, 1'b0, '0);
            end else if (r < 12) begin
                // stray reading that breaks the sequence
                drive_txn(FUNC_SAMPLE, $urandom, $urandom, 1'b0, '0);
            end else begin
                span = ((cpu_cfg == '0) ? 64'd1 : 64'(cpu_cfg)) * 64'd8 + 64'd16;
                if ($urandom_range(0, 9) == 0)
                    delta = 64'($urandom);
                else
                    delta = 64'($urandom_range(0, int'(span)));
                if (delta <= counter)
                    counter = counter - delta;
                else
                    counter = (64'(period_cfg) - (delta - counter)) & CNT_MASK;
                seq_left--;
                drive_txn(FUNC_SAMPLE, counter[TV_BITS-1:0], $urandom, 1'b0, '0);
            end
            pace_sender();
        end
    endtask

    // output side: stall in runs, with occasional long calm stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_run   <= 0;
        end else if (stall_run == 0) begin
            case ($urandom_range(0, 9))
                0: begin
                    i_out_stall <= 1'b0;
                    stall_run   <= $urandom_range(200, 600);
                end
                1, 2, 3, 4: begin
                    i_out_stall <= 1'b0;
                    stall_run   <= $urandom_range(1, 30);
                end
                8: begin
                    i_out_stall <= 1'b1;
                    stall_run   <= $urandom_range(20, 40);
                end
                default: begin
                    i_out_stall <= 1'b1;
                    stall_run   <= $urandom_range(1, 8);
                end
            endcase
        end else begin
            stall_run <= stall_run - 1;
        end
    end

    always @(posedge i_clk) begin
        t_delay_result exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_elapsed_q.size() == 0) begin
                flag_error($sformatf("unexpected result done=%0b elapsed=%h",
                                     o_done_res, o_elapsed_usecs));
            end else begin
                exp_res = pending_elapsed_q.pop_front();
                if (o_done_res !== exp_res.done || o_elapsed_usecs !== exp_res.elapsed)
                    flag_error($sformatf("mismatch: exp done=%0b elapsed=%h, got done=%0b elapsed=%h",
                                         exp_res.done, exp_res.elapsed,
                                         o_done_res, o_elapsed_usecs));
            end
        end
    end

    initial begin
        int            ph;
        int            i;
        logic [15:0]   cpu;
        logic [31:0]   per;

        directed_rows = '{
            // sample before any start: goal is zero, so already done
            '{FUNC_SAMPLE, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'h0}},
            '{FUNC_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '{1'b0, 32'h0}},
            // zero target is done at once
            '{FUNC_START,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b1, 32'h0}},
            '{FUNC_START,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0}},
            // full count down at one count per usec saturates
            '{FUNC_SAMPLE, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF}},
            '{FUNC_SAMPLE, 32'h0000_0000, 32'h0000_0005, 1'b1, '{1'b1, 32'hFFFF_FFFF}},
            '{FUNC_START,  32'h0000_03E8, 32'h0000_000A, 1'b1, '{1'b0, 32'h0}},
            '{FUNC_SAMPLE, 32'h0000_03E3, 32'h0000_0000, 1'b0, '{1'b0, 32'h0}},
            '{FUNC_SAMPLE, 32'h0000_03DE, 32'h0000_0000, 1'b0, '{1'b0, 32'h0}},
            '{FUNC_SAMPLE, 32'h0000_03DE, 32'h0000_0000, 1'b0, '{1'b0, 32'h0}},
            // reading above the previous one: wrap through the period
            '{FUNC_SAMPLE, 32'h0000_07D0, 32'h0000_0000, 1'b0, '{1'b0, 32'h0}},
            '{FUNC_START,  32'h1234_5678, 32'h8000_0000, 1'b1, '{1'b0, 32'h0}},
            '{FUNC_SAMPLE, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '{1'b0, 32'h0}},
            '{FUNC_SAMPLE, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '{1'b0, 32'h0}},
            '{FUNC_SAMPLE, 32'h0000_0000, 32'h0000_0000, 1'b0, '{1'b0, 32'h0}},
            '{FUNC_START,  32'h0000_0000, 32'h0000_0001, 1'b1, '{1'b0, 32'h0}},
            '{FUNC_SAMPLE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '{1'b0, 32'h0}}
        };

        cpu_cfg      = 16'd1;
        period_cfg   = 32'hFFFF_FFFF;
        last_reading = '0;
        spare_counts = '0;
        usec_total   = '0;
        goal_usecs   = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < N_DIRECTED; i++) begin
            drive_txn(directed_rows[i].func, directed_rows[i].tv, directed_rows[i].tgt,
                      directed_rows[i].typed, directed_rows[i].res);
            pace_sender();
        end

        for (ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    cpu = 16'hFFFF;
                    per = 32'hFFFF_FFFF;
                end
                1: begin
                    // zero counts per usec acts as one, zero period
                    cpu = 16'h0000;
                    per = 32'h0000_0000;
                end
                2: begin
                    cpu = 16'h0001;
                    per = 32'h0000_0001;
                end
                3: begin
                    cpu = $urandom_range(2, 1000);
                    per = $urandom;
                end
                4: begin
                    cpu = $urandom_range(2, 20);
                    per = $urandom_range(1000, 100000);
                end
                default: begin
                    cpu = $urandom_range(1, 65535);
                    per = 32'hFFFF_FFFF;
                end
            endcase
            reconfigure(cpu, per);
            run_random(ITEMS_PHASE);
        end

        i_in_valid <= 1'b0;
        while (pending_elapsed_q.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        if (err_cnt == 0 && pending_elapsed_q.size() == 0)
            $display("polled_timer_usec_delay_top_tb: PASS");
        else
            $display("polled_timer_usec_delay_top_tb: FAIL");
        $finish;
    end

endmodule

>>> polled_timer_usec_delay_top.f
hw/rtl/ptud_pkg.sv
hw/rtl/ptud_div.sv
hw/rtl/polled_timer_usec_delay_top.sv
tb/polled_timer_usec_delay_top_tb.sv
